>>> hw/rtl/btk_pkg.sv
package btk_pkg;

	localparam int MAX_WIDTH_DEF = 256;
	localparam int APB_AW        = 3;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_PUSH  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [APB_AW-1:0] ADDR_WIDTH_CFG = 3'd0;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] score;
		logic [63:0]        hash;
		logic [15:0]        parent_index;
		logic [31:0]        action_code;
		logic [23:0]        node_id;
		logic [15:0]        turn_tag;
		logic [7:0]         read_index;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic               evicted_valid;
		logic [23:0]        evicted_node_id;
		logic signed [31:0] threshold_score;
		logic               threshold_is_inf;
		logic [8:0]         entry_count;
		logic signed [31:0] rd_score;
		logic [63:0]        rd_hash;
		logic [15:0]        rd_parent;
		logic [31:0]        rd_action;
		logic [23:0]        rd_node_id;
		logic [15:0]        rd_turn_tag;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [63:0]        hash;
		logic [15:0]        parent;
		logic [31:0]        action;
		logic [23:0]        node_id;
		logic [15:0]        turn;
	} slot_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_run;
		logic commit;
		logic thr_take;
		logic rd_issue;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic       scan_done;
		logic [1:0] kind;
	} sts_t;

endpackage

>>> hw/rtl/btk_if.sv
interface btk_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] score;
	logic [63:0]        hash;
	logic [15:0]        parent_index;
	logic [31:0]        action_code;
	logic [23:0]        node_id;
	logic [15:0]        turn_tag;
	logic [7:0]         read_index;

	modport source (output valid, kind, score, hash, parent_index, action_code, node_id,
		turn_tag, read_index, input ready);
	modport sink (input valid, kind, score, hash, parent_index, action_code, node_id,
		turn_tag, read_index, output ready);
endinterface

interface btk_out_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic               evicted_valid;
	logic [23:0]        evicted_node_id;
	logic signed [31:0] threshold_score;
	logic               threshold_is_inf;
	logic [8:0]         entry_count;
	logic signed [31:0] rd_score;
	logic [63:0]        rd_hash;
	logic [15:0]        rd_parent;
	logic [31:0]        rd_action;
	logic [23:0]        rd_node_id;
	logic [15:0]        rd_turn_tag;

	modport source (output valid, accepted, evicted_valid, evicted_node_id, threshold_score,
		threshold_is_inf, entry_count, rd_score, rd_hash, rd_parent, rd_action, rd_node_id,
		rd_turn_tag, input ready);
	modport sink (input valid, accepted, evicted_valid, evicted_node_id, threshold_score,
		threshold_is_inf, entry_count, rd_score, rd_hash, rd_parent, rd_action, rd_node_id,
		rd_turn_tag, output ready);
endinterface

>>> hw/rtl/btk_ctrl.sv
module btk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic [1:0]    in_kind,
	input  btk_pkg::sts_t sts,
	output btk_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN1  = 3'd1;
	localparam logic [2:0] S_COMMIT = 3'd2;
	localparam logic [2:0] S_SCAN2  = 3'd3;
	localparam logic [2:0] S_RD     = 3'd4;
	localparam logic [2:0] S_RDT    = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0] state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_kind == btk_pkg::KIND_PUSH) begin
						cmd.scan_start = 1'b1;
						state_d = S_SCAN1;
					end else if (in_kind == btk_pkg::KIND_CLEAR) begin
						state_d = S_COMMIT;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_SCAN1: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				if (sts.kind == btk_pkg::KIND_PUSH) begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN2;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_SCAN2: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					cmd.thr_take = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d = S_RDT;
			end
			S_RDT: begin
				cmd.emit = 1'b1;
				state_d = S_OUT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while result pending");
	a_emit_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid) else $error("emit not followed by result");

endmodule

>>> hw/rtl/btk_dp.sv
module btk_dp #(
	parameter int MaxWidth = btk_pkg::MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  btk_pkg::cmd_t     cmd,
	output btk_pkg::sts_t     sts,
	input  btk_pkg::in_item_t in_item,
	input  logic [8:0]        width_cfg,
	output btk_pkg::out_item_t out_item
);

	localparam int AW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
	localparam int CW = $clog2(MaxWidth + 1);
	localparam int RstWidth = (MaxWidth < 256) ? MaxWidth : 256;

	btk_pkg::slot_t mem [MaxWidth];
	btk_pkg::slot_t rdata_q;
	btk_pkg::in_item_t in_q;
	btk_pkg::out_item_t out_q;

	logic [CW-1:0] count_q, wiu_q, idx_q;
	logic [AW-1:0] rd_addr, pidx_s1, wr_addr;
	logic          pend_s1, wr_en;

	logic               found_q, have_max_q;
	logic [AW-1:0]      midx_q, maxidx_q;
	logic signed [31:0] mscore_q, max_q, thr_q;
	logic [23:0]        mnode_q, maxnode_q;
	logic               acc_q, ev_q;
	logic [23:0]        evid_q;

	logic full, rd_ok;

	assign full = (count_q >= wiu_q);
	assign sts.scan_done = cmd.scan_run && (idx_q >= count_q) && !pend_s1;
	assign sts.kind = in_q.kind;
	assign rd_ok = (in_q.kind == btk_pkg::KIND_READ) &&
		(32'(in_q.read_index) < 32'(count_q));

	always_comb begin
		if (cmd.rd_issue) rd_addr = AW'(in_q.read_index);
		else rd_addr = idx_q[AW-1:0];
	end

	// commit decision for a push
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		if (cmd.commit && in_q.kind == btk_pkg::KIND_PUSH &&
			!(full && !(in_q.score < max_q))) begin
			if (found_q) begin
				wr_en   = (in_q.score < mscore_q);
				wr_addr = midx_q;
			end else if (!full) begin
				wr_en   = 1'b1;
			end else begin
				wr_en   = 1'b1;
				wr_addr = maxidx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= '{score: in_q.score, hash: in_q.hash,
			parent: in_q.parent_index, action: in_q.action_code,
			node_id: in_q.node_id, turn: in_q.turn_tag};
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wiu_q   <= CW'(RstWidth);
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_s1 <= (idx_q < count_q);
				if (idx_q < count_q) idx_q <= idx_q + 1'b1;
			end
			if (cmd.commit) begin
				if (in_q.kind == btk_pkg::KIND_CLEAR) begin
					count_q <= '0;
					if (width_cfg == 9'd0) wiu_q <= CW'(1);
					else if (32'(width_cfg) > MaxWidth) wiu_q <= CW'(MaxWidth);
					else wiu_q <= CW'(width_cfg);
				end else if (wr_en && !found_q && !full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// scan accumulators and result fields
	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_item;
		pidx_s1 <= idx_q[AW-1:0];
		if (cmd.scan_start) begin
			found_q    <= 1'b0;
			have_max_q <= 1'b0;
		end else if (cmd.scan_run && pend_s1) begin
			if (!found_q && rdata_q.hash == in_q.hash) begin
				found_q  <= 1'b1;
				midx_q   <= pidx_s1;
				mscore_q <= rdata_q.score;
				mnode_q  <= rdata_q.node_id;
			end
			// ties go to the later slot
			if (!have_max_q || !(rdata_q.score < max_q)) begin
				have_max_q <= 1'b1;
				max_q      <= rdata_q.score;
				maxidx_q   <= pidx_s1;
				maxnode_q  <= rdata_q.node_id;
			end
		end
		if (cmd.load) begin
			acc_q  <= 1'b0;
			ev_q   <= 1'b0;
			evid_q <= '0;
		end else if (wr_en) begin
			acc_q  <= 1'b1;
			ev_q   <= found_q || full;
			evid_q <= found_q ? mnode_q : (full ? maxnode_q : 24'd0);
		end
		if (cmd.thr_take) thr_q <= max_q;
		if (cmd.emit) begin
			out_q.accepted         <= acc_q;
			out_q.evicted_valid    <= ev_q;
			out_q.evicted_node_id  <= evid_q;
			out_q.threshold_score  <= full ? thr_q : 32'sd0;
			out_q.threshold_is_inf <= !full;
			out_q.entry_count      <= 9'(count_q);
			out_q.rd_score         <= rd_ok ? rdata_q.score : 32'sd0;
			out_q.rd_hash          <= rd_ok ? rdata_q.hash : 64'd0;
			out_q.rd_parent        <= rd_ok ? rdata_q.parent : 16'd0;
			out_q.rd_action        <= rd_ok ? rdata_q.action : 32'd0;
			out_q.rd_node_id       <= rd_ok ? rdata_q.node_id : 24'd0;
			out_q.rd_turn_tag      <= rd_ok ? rdata_q.turn : 16'd0;
		end
	end

	assign out_item = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wiu_q) else $error("count above width in use");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == '0 || count_q == $past(count_q) + 1'b1)
		else $error("count jumped");

endmodule

>>> hw/rtl/beam_topk_dedup_keeper.sv
// Keeps up to the configured width of lowest-score candidates with duplicate elimination
// by hash. One item at a time: a push makes two passes over the slot memory (one slot per
// cycle through its registered read port), the first for the hash match and maximum, the
// second for the new threshold; a clear passes through a commit and an emit state, and a
// read through a read issue and an emit state, before the result beat.
// The width register takes effect at a clear.
module beam_topk_dedup_keeper #(
	parameter int MaxWidth = btk_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	btk_in_if.sink                     req,
	btk_out_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [btk_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	btk_pkg::cmd_t      cmd;
	btk_pkg::sts_t      sts;
	btk_pkg::in_item_t  in_item;
	btk_pkg::out_item_t out_item;
	logic [8:0]         width_cfg_q;

	assign pready = 1'b1;
	assign prdata = (paddr == btk_pkg::ADDR_WIDTH_CFG) ? {23'd0, width_cfg_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) width_cfg_q <= 9'd256;
		else if (psel && penable && pwrite && paddr == btk_pkg::ADDR_WIDTH_CFG)
			width_cfg_q <= pwdata[8:0];
	end

	assign in_item = '{kind: req.kind, score: req.score, hash: req.hash,
		parent_index: req.parent_index, action_code: req.action_code,
		node_id: req.node_id, turn_tag: req.turn_tag, read_index: req.read_index};

	btk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.in_kind  (req.kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	btk_dp #(.MaxWidth(MaxWidth)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.width_cfg (width_cfg_q),
		.out_item  (out_item)
	);

	assign rsp.accepted         = out_item.accepted;
	assign rsp.evicted_valid    = out_item.evicted_valid;
	assign rsp.evicted_node_id  = out_item.evicted_node_id;
	assign rsp.threshold_score  = out_item.threshold_score;
	assign rsp.threshold_is_inf = out_item.threshold_is_inf;
	assign rsp.entry_count      = out_item.entry_count;
	assign rsp.rd_score         = out_item.rd_score;
	assign rsp.rd_hash          = out_item.rd_hash;
	assign rsp.rd_parent        = out_item.rd_parent;
	assign rsp.rd_action        = out_item.rd_action;
	assign rsp.rd_node_id       = out_item.rd_node_id;
	assign rsp.rd_turn_tag      = out_item.rd_turn_tag;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] KIND_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [btk_pkg::APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	btk_in_if req_ch ();
	btk_out_if rsp_ch ();

	beam_topk_dedup_keeper dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// keeper state as the predictor sees it
	btk_pkg::slot_t slots [btk_pkg::MAX_WIDTH_DEF];
	int occupied;
	int width_used;
	logic [8:0] width_cfg_reg;

	btk_pkg::in_item_t pending [$];
	btk_pkg::out_item_t expected_rsp [$];
	btk_pkg::in_item_t cur_item;
	int send_gap;
	int recv_stall;
	bit no_idle;
	int bad_beats;
	logic [63:0] hash_pool [8];

	task automatic queue_item(input btk_pkg::in_item_t it);
		pending.insert(pending.size(), it);
	endtask

	function automatic int max_slot();
		int best;
		best = 0;
		for (int i = 1; i < occupied; i++)
			if (!(slots[i].score < slots[best].score))
				best = i;
		return best;
	endfunction

	task automatic write_slot(input int i, input btk_pkg::in_item_t it);
		slots[i].score = it.score;
		slots[i].hash = it.hash;
		slots[i].parent = it.parent_index;
		slots[i].action = it.action_code;
		slots[i].node_id = it.node_id;
		slots[i].turn = it.turn_tag;
	endtask

	task automatic keeper_step(input btk_pkg::in_item_t it, output btk_pkg::out_item_t r);
		bit full;
		bit rej;
		bit found;
		int m;
		int idx;
		r = '0;
		case (it.kind)
			btk_pkg::KIND_CLEAR: begin
				width_used = (width_cfg_reg == 0) ? 1 :
					(width_cfg_reg > btk_pkg::MAX_WIDTH_DEF) ? btk_pkg::MAX_WIDTH_DEF :
					int'(width_cfg_reg);
				occupied = 0;
			end
			btk_pkg::KIND_PUSH: begin
				full = occupied >= width_used;
				rej = 0;
				m = 0;
				if (full) begin
					m = max_slot();
					if (!(it.score < slots[m].score))
						rej = 1;
				end
				if (!rej) begin
					found = 0;
					idx = 0;
					for (int i = 0; i < occupied; i++)
						if (!found && slots[i].hash == it.hash) begin
							found = 1;
							idx = i;
						end
					if (found) begin
						if (it.score < slots[idx].score) begin
							r.evicted_valid = 1'b1;
							r.evicted_node_id = slots[idx].node_id;
							write_slot(idx, it);
							r.accepted = 1'b1;
						end
					end else if (!full) begin
						write_slot(occupied, it);
						occupied++;
						r.accepted = 1'b1;
					end else begin
						r.evicted_valid = 1'b1;
						r.evicted_node_id = slots[m].node_id;
						write_slot(m, it);
						r.accepted = 1'b1;
					end
				end
			end
			btk_pkg::KIND_READ: begin
				if (it.read_index < occupied) begin
					r.rd_score = slots[it.read_index].score;
					r.rd_hash = slots[it.read_index].hash;
					r.rd_parent = slots[it.read_index].parent;
					r.rd_action = slots[it.read_index].action;
					r.rd_node_id = slots[it.read_index].node_id;
					r.rd_turn_tag = slots[it.read_index].turn;
				end
			end
			default: ;
		endcase
		if (occupied < width_used)
			r.threshold_is_inf = 1'b1;
		else
			r.threshold_score = slots[max_slot()].score;
		r.entry_count = occupied[8:0];
	endtask

	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// driver
	always @(posedge clk) begin
		btk_pkg::out_item_t r;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				keeper_step(cur_item, r);
				expected_rsp.insert(expected_rsp.size(), r);
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur_item = pending.pop_front();
					req_ch.kind <= cur_item.kind;
					req_ch.score <= cur_item.score;
					req_ch.hash <= cur_item.hash;
					req_ch.parent_index <= cur_item.parent_index;
					req_ch.action_code <= cur_item.action_code;
					req_ch.node_id <= cur_item.node_id;
					req_ch.turn_tag <= cur_item.turn_tag;
					req_ch.read_index <= cur_item.read_index;
					req_ch.valid <= 1'b1;
					send_gap = draw_wait();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		btk_pkg::out_item_t got;
		btk_pkg::out_item_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.accepted, rsp_ch.evicted_valid, rsp_ch.evicted_node_id,
					rsp_ch.threshold_score, rsp_ch.threshold_is_inf, rsp_ch.entry_count,
					rsp_ch.rd_score, rsp_ch.rd_hash, rsp_ch.rd_parent, rsp_ch.rd_action,
					rsp_ch.rd_node_id, rsp_ch.rd_turn_tag};
				if (expected_rsp.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("unexpected beat: %p", got);
				end else begin
					want = expected_rsp.pop_front();
					if (got !== want) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display("beat differs\n  expected %p\n  actual   %p", want, got);
					end
				end
				recv_stall = draw_wait();
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			rsp_ch.ready <= (recv_stall == 0);
		end
	end

	task automatic cfg_write(input logic [8:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= btk_pkg::ADDR_WIDTH_CFG;
		pwdata <= {23'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		width_cfg_reg = v;
	endtask

	task automatic wait_idle();
		while (pending.size() > 0 || req_ch.valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic btk_pkg::in_item_t mk(input logic [1:0] k,
			input logic signed [31:0] s, input logic [63:0] h, input logic [7:0] ri);
		btk_pkg::in_item_t it;
		it.kind = k;
		it.score = s;
		it.hash = h;
		it.parent_index = 16'($urandom);
		it.action_code = $urandom;
		it.node_id = 24'($urandom);
		it.turn_tag = 16'($urandom);
		it.read_index = ri;
		return it;
	endfunction

	function automatic btk_pkg::in_item_t rand_item(input int w);
		int sel;
		logic signed [31:0] s;
		logic [63:0] h;
		logic [1:0] k;
		sel = $urandom_range(0, 99);
		k = sel < 70 ? btk_pkg::KIND_PUSH : sel < 88 ? btk_pkg::KIND_READ :
			sel < 94 ? btk_pkg::KIND_CLEAR : KIND_NONE;
		case ($urandom_range(0, 9))
			0: s = 32'sh8000_0000;
			1: s = 32'sh7fff_ffff;
			2, 3, 4: s = $urandom;
			default: s = $signed($urandom_range(0, 16)) - 8;
		endcase
		h = $urandom_range(0, 1) ? hash_pool[$urandom_range(0, 7)] : {$urandom, $urandom};
		return mk(k, s, h, $urandom_range(0, 3) == 0 ? 8'($urandom) :
			8'($urandom_range(0, w + 2 > 255 ? 255 : w + 2)));
	endfunction

	initial begin
		int widths [];
		widths = '{0, 1, 2, 3, 5, 8, 16, 511, 4, 1, 7, 33, 2, 257, 6, 255, 3};
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.score = '0;
		req_ch.hash = '0;
		req_ch.parent_index = '0;
		req_ch.action_code = '0;
		req_ch.node_id = '0;
		req_ch.turn_tag = '0;
		req_ch.read_index = '0;
		rsp_ch.ready = 1'b0;
		occupied = 0;
		width_used = btk_pkg::MAX_WIDTH_DEF;
		width_cfg_reg = 9'd256;
		send_gap = 0;
		recv_stall = 0;
		no_idle = 0;
		bad_beats = 0;
		for (int i = 0; i < 8; i++)
			hash_pool[i] = {$urandom, $urandom};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, duplicates, unused kind
		queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'd0));
		queue_item(mk(KIND_NONE, 5, 64'd1, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 32'sh8000_0000, 64'hffff_ffff_ffff_ffff, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 32'sh7fff_ffff, 64'd0, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 10, 64'd0, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 10, 64'd0, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 20, 64'd0, 8'd0));
		queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'd1));
		queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'd2));
		queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'd3));
		queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'd255));
		queue_item(mk(btk_pkg::KIND_CLEAR, 0, 64'd0, 8'd0));
		wait_idle();
		// width 0 clamps to one slot
		cfg_write(9'd0);
		queue_item(mk(btk_pkg::KIND_CLEAR, 0, 64'd0, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 3, 64'd7, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 3, 64'd8, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 9, 64'd8, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 2, 64'd8, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 1, 64'd8, 8'd0));
		queue_item(mk(btk_pkg::KIND_PUSH, 32'sh8000_0000, 64'd9, 8'd0));
		queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'd0));
		// sender holds until the table has answered everything
		wait_idle();

		foreach (widths[p]) begin
			no_idle = (p % 5 == 2);
			cfg_write(9'(widths[p]));
			queue_item(mk(btk_pkg::KIND_CLEAR, 0, 64'd0, 8'd0));
			for (int n = 0; n < 50; n++)
				queue_item(rand_item(widths[p] > 255 ? 255 : widths[p]));
			wait_idle();
		end

		// fill the widest table and evict from it
		no_idle = 0;
		cfg_write(9'd256);
		queue_item(mk(btk_pkg::KIND_CLEAR, 0, 64'd0, 8'd0));
		for (int n = 0; n < 280; n++)
			queue_item(n % 10 == 9 ? rand_item(255) :
				mk(btk_pkg::KIND_PUSH, $urandom, {$urandom, $urandom}, 8'd0));
		for (int n = 0; n < 20; n++)
			queue_item(mk(btk_pkg::KIND_READ, 0, 64'd0, 8'($urandom)));
		wait_idle();
		repeat (20) @(posedge clk);

		if (bad_beats == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#30ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/btk_pkg.sv
hw/rtl/btk_if.sv
hw/rtl/btk_ctrl.sv
hw/rtl/btk_dp.sv
hw/rtl/beam_topk_dedup_keeper.sv
test/tb.sv
